// ===== design/spc_pkg.sv =====
// Shared types, constants and fixed-point helpers for the surfel project-and-cull core.
// No dependencies; every other design file imports this package.
package spc_pkg;

  localparam int FRAC_BITS = 16;

  // reciprocal divider: numerator 2^(2*FRAC_BITS), one quotient bit per step
  localparam int DIV_BITS   = 2 * FRAC_BITS + 1;
  localparam int STEP_BITS  = 4;
  localparam int DIV_STAGES = (DIV_BITS + STEP_BITS - 1) / STEP_BITS;

  // bounds compare width: view size shifted up plus pad, signed
  localparam int BND_W = 14 + FRAC_BITS + 3;

  // register map
  typedef enum logic [2:0] {
    REG_NEAR     = 3'd0,
    REG_FAR      = 3'd1,
    REG_SCALE_X  = 3'd2,
    REG_SCALE_Y  = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5,
    REG_WIDTH    = 3'd6,
    REG_HEIGHT   = 3'd7
  } reg_idx_t;

  localparam logic [30:0] NEAR_RST  = 31'd65536;
  localparam logic [30:0] FAR_RST   = 31'h7FFF_FFFF;
  localparam logic [30:0] SCALE_RST = 31'd65536;
  localparam logic [13:0] VIEW_RST  = 14'd512;

  localparam logic REQ_LOAD = 1'b0;

  localparam int N_MODEL  = 12;
  localparam int N_NORMAL = 9;

  typedef logic [N_MODEL-1:0][31:0]  mcoef_t;
  typedef logic [N_NORMAL-1:0][31:0] ncoef_t;

  typedef struct packed {
    logic [30:0]        near_plane;
    logic [30:0]        far_plane;
    logic [30:0]        scale_x;
    logic [30:0]        scale_y;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic [13:0]        view_width;
    logic [13:0]        view_height;
  } cfg_t;

  // surfel fields as they arrive
  typedef struct packed {
    logic               invisible;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        radius;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
  } surf_t;

  // camera-space item after the transform and depth test
  typedef struct packed {
    logic               ok;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        radius;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic [30:0]        pad_x;
    logic [30:0]        pad_y;
    logic signed [31:0] cam_nrm_x;
    logic signed [31:0] cam_nrm_y;
    logic signed [31:0] cam_nrm_z;
  } res_t;

  // pipeline occupancy, one flag per unit
  typedef struct packed {
    logic xform;
    logic recip;
    logic view;
  } busy_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    else if (v < -64'sh8000_0000) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  function automatic logic [30:0] satu31(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 31'h7FFF_FFFF;
    else if (v < 64'sh0) return 31'h0;
    else return v[30:0];
  endfunction

  // one matrix row: floor-shifted products, summed exactly, then saturated
  function automatic logic signed [31:0] row_sum(input logic signed [63:0] p0,
                                                 input logic signed [63:0] p1,
                                                 input logic signed [63:0] p2,
                                                 input logic signed [31:0] t);
    logic signed [63:0] s;
    s = (p0 >>> FRAC_BITS) + (p1 >>> FRAC_BITS) + (p2 >>> FRAC_BITS) + 64'(t);
    return sat32(s);
  endfunction

endpackage

// ===== design/spc_xform.sv =====
// Camera-space transform of position and normal plus depth test, three stages.
// Depends on spc_pkg.
module spc_xform import spc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  logic   in_vld,
  input  surf_t  in_s,
  input  mcoef_t mc,
  input  ncoef_t nc,
  input  cfg_t   cfg,
  output logic   out_vld,
  output item_t  out_it,
  output logic   busy
);

  logic               v1, v2;
  logic signed [63:0] pm [9];
  logic signed [63:0] pn [9];
  logic               inv1, inv2;
  logic [30:0]        rad1, rad2;
  logic signed [31:0] cx2, cy2, cz2, nx2, ny2, nz2;
  logic signed [31:0] pos [3];
  logic signed [31:0] nrm [3];
  logic               z_ok;

  assign pos[0] = in_s.pos_x;
  assign pos[1] = in_s.pos_y;
  assign pos[2] = in_s.pos_z;
  assign nrm[0] = in_s.nrm_x;
  assign nrm[1] = in_s.nrm_y;
  assign nrm[2] = in_s.nrm_z;

  // stage 1: nine position and nine normal products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_vld;
    end
    if (adv) begin
      for (int k = 0; k < 9; k++) begin
        pm[k] <= $signed(mc[k]) * pos[k % 3];
        pn[k] <= $signed(nc[k]) * nrm[k % 3];
      end
      inv1 <= in_s.invisible;
      rad1 <= in_s.radius;
    end
  end

  // stage 2: row sums with translation, saturated
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      cx2  <= row_sum(pm[0], pm[1], pm[2], $signed(mc[9]));
      cy2  <= row_sum(pm[3], pm[4], pm[5], $signed(mc[10]));
      cz2  <= row_sum(pm[6], pm[7], pm[8], $signed(mc[11]));
      nx2  <= row_sum(pn[0], pn[1], pn[2], 32'sd0);
      ny2  <= row_sum(pn[3], pn[4], pn[5], 32'sd0);
      nz2  <= row_sum(pn[6], pn[7], pn[8], 32'sd0);
      inv2 <= inv1;
      rad2 <= rad1;
    end
  end

  // stage 3: visibility and strict near/far test on saturated depth
  assign z_ok = !inv2 && (cz2 > $signed({1'b0, cfg.near_plane}))
                && (cz2 < $signed({1'b0, cfg.far_plane})) && (cz2 > 32'sd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= v2;
    end
    if (adv) begin
      out_it.ok     <= z_ok;
      out_it.cx     <= cx2;
      out_it.cy     <= cy2;
      out_it.cz     <= cz2;
      out_it.radius <= rad2;
      out_it.nx     <= nx2;
      out_it.ny     <= ny2;
      out_it.nz     <= nz2;
    end
  end

  assign busy = v1 | v2 | out_vld;

endmodule

// ===== design/spc_recip.sv =====
// Pipelined restoring divider giving floor(2^(2*FRAC_BITS) / cam_z), saturated.
// Depends on spc_pkg; STEP_BITS quotient bits per stage, item carried alongside.
module spc_recip import spc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_vld,
  input  item_t       in_it,
  output logic        out_vld,
  output item_t       out_it,
  output logic [30:0] recip,
  output logic        busy
);

  typedef struct packed {
    logic                vld;
    item_t               it;
    logic [31:0]         rem;
    logic [DIV_BITS-1:0] quo;
  } dstage_t;

  dstage_t pipe [DIV_STAGES+1];

  assign pipe[0].vld = in_vld;
  assign pipe[0].it  = in_it;
  assign pipe[0].rem = '0;
  assign pipe[0].quo = '0;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
    logic [31:0]         r_n;
    logic [DIV_BITS-1:0] q_n;
    logic [31:0]         dv;

    assign dv = {1'b0, pipe[k].it.cz[30:0]};

    // up to STEP_BITS shift-and-subtract steps (fewer in the last stage); only the top numerator bit is set
    always_comb begin
      r_n = pipe[k].rem;
      q_n = pipe[k].quo;
      for (int j = 0; j < STEP_BITS; j++) begin
        if (k * STEP_BITS + j < DIV_BITS) begin
          r_n = {r_n[30:0], (k * STEP_BITS + j == 0)};
          if (r_n >= dv) begin
            r_n = r_n - dv;
            q_n = {q_n[DIV_BITS-2:0], 1'b1};
          end else begin
            q_n = {q_n[DIV_BITS-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[k+1].vld <= 1'b0;
      end else if (adv) begin
        pipe[k+1].vld <= pipe[k].vld;
      end
      if (adv) begin
        pipe[k+1].it  <= pipe[k].it;
        pipe[k+1].rem <= r_n;
        pipe[k+1].quo <= q_n;
      end
    end
  end

  assign out_vld = pipe[DIV_STAGES].vld;
  assign out_it  = pipe[DIV_STAGES].it;
  assign recip   = ({{(64-DIV_BITS){1'b0}}, pipe[DIV_STAGES].quo} > 64'h7FFF_FFFF)
                   ? 31'h7FFF_FFFF : pipe[DIV_STAGES].quo[30:0];

  always_comb begin
    busy = 1'b0;
    for (int k = 1; k <= DIV_STAGES; k++) busy = busy | pipe[k].vld;
  end

endmodule

// ===== design/spc_viewport.sv =====
// Perspective divide, viewport map, pad projection and bounds test; four stages,
// the last one being the output register. Depends on spc_pkg.
module spc_viewport import spc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_vld,
  input  item_t       in_it,
  input  logic [30:0] recip,
  input  cfg_t        cfg,
  output logic        out_vld,
  output res_t        out_r,
  output logic        busy
);

  logic               v1, v2, v3;
  item_t              it1, it2, it3;
  logic signed [63:0] uxp, uyp, rpp;
  logic signed [31:0] tx, ty;
  logic [30:0]        rp;
  logic signed [63:0] sxp, syp, pxp, pyp;
  logic signed [31:0] sx, sy;
  logic [30:0]        px, py;
  logic signed [BND_W-1:0] sxw, syw, pxw, pyw, wlim, hlim;
  logic               in_bnd;
  res_t               res;

  // stage 1: multiply by the reciprocal
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_vld;
    end
    if (adv) begin
      uxp <= in_it.cx * $signed({1'b0, recip});
      uyp <= in_it.cy * $signed({1'b0, recip});
      rpp <= $signed({1'b0, in_it.radius}) * $signed({1'b0, recip});
      it1 <= in_it;
    end
  end

  // stage 2: shift, saturate, add offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      tx  <= sat32(64'(sat32(uxp >>> FRAC_BITS)) + 64'(cfg.offset_x));
      ty  <= sat32(64'(sat32(uyp >>> FRAC_BITS)) + 64'(cfg.offset_y));
      rp  <= satu31(rpp >>> FRAC_BITS);
      it2 <= it1;
    end
  end

  // stage 3: viewport scale of position and pads
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      sxp <= tx * $signed({1'b0, cfg.scale_x});
      syp <= ty * $signed({1'b0, cfg.scale_y});
      pxp <= $signed({1'b0, rp}) * $signed({1'b0, cfg.scale_x});
      pyp <= $signed({1'b0, rp}) * $signed({1'b0, cfg.scale_y});
      it3 <= it2;
    end
  end

  // stage 4: saturate, padded bounds test, zero rejected results
  assign sx   = sat32(sxp >>> FRAC_BITS);
  assign sy   = sat32(syp >>> FRAC_BITS);
  assign px   = satu31(pxp >>> FRAC_BITS);
  assign py   = satu31(pyp >>> FRAC_BITS);
  assign sxw  = BND_W'(sx);
  assign syw  = BND_W'(sy);
  assign pxw  = $signed(BND_W'(px));
  assign pyw  = $signed(BND_W'(py));
  assign wlim = $signed(BND_W'(cfg.view_width) << FRAC_BITS);
  assign hlim = $signed(BND_W'(cfg.view_height) << FRAC_BITS);
  assign in_bnd = (sxw >= -pxw) && (sxw < wlim + pxw)
                  && (syw >= -pyw) && (syw < hlim + pyw);

  always_comb begin
    res = '0;
    if (it3.ok && in_bnd) begin
      res.accepted  = 1'b1;
      res.screen_x  = sx;
      res.screen_y  = sy;
      res.cam_x     = it3.cx;
      res.cam_y     = it3.cy;
      res.cam_z     = it3.cz;
      res.pad_x     = px;
      res.pad_y     = py;
      res.cam_nrm_x = it3.nx;
      res.cam_nrm_y = it3.ny;
      res.cam_nrm_z = it3.nz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= v3;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign busy = v1 | v2 | v3 | out_vld;

endmodule

// ===== design/surfel_project_and_cull_core.sv =====
// From surfel transfer to result, a surfel passes the transform, divider and viewport stages (Q16.16).
// Throughput: one surfel per cycle while m_tready keeps the pipe advancing; the divider is fully pipelined.
// Coefficient loads are taken only once the pipe has drained and give no result.
// Reset (synchronous, active high) clears all valid bits, zeroes the coefficient
// store and loads the register defaults. Depends on spc_pkg and the spc_* units.
module surfel_project_and_cull_core import spc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // coef_index[4:0], coef_value[36:5], invisible[37], pos_x[69:38], pos_y[101:70],
  // pos_z[133:102], radius[164:134], nrm_x[196:165], nrm_y[228:197], nrm_z[260:229]
  input  logic [263:0] s_tdata,
  input  logic [0:0]   s_tuser,   // req_type[0]
  input  logic         s_tvalid,
  output logic         s_tready,
  // screen_x[31:0], screen_y[63:32], cam_x[95:64], cam_y[127:96], cam_z[159:128],
  // pad_x[190:160], pad_y[221:191], cam_nrm_x[253:222], cam_nrm_y[285:254],
  // cam_nrm_z[317:286]
  output logic [319:0] m_tdata,
  output logic [0:0]   m_tuser,   // accepted[0]
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t   cfg;
  mcoef_t mc;
  ncoef_t nc;
  busy_t  busy;
  logic   adv, empty, in_xfer, load_xfer;
  surf_t  surf;
  logic   x_vld, r_vld;
  item_t  x_it, r_it;
  logic [30:0] recip;
  res_t   res;
  logic [4:0]  cidx;
  reg_idx_t    widx, ridx;

  assign adv       = !m_tvalid || m_tready;
  assign empty     = !(busy.xform || busy.recip || busy.view);
  assign s_tready  = adv && (s_tuser[0] != REQ_LOAD || empty);
  assign in_xfer   = s_tvalid && s_tready && (s_tuser[0] != REQ_LOAD);
  assign load_xfer = s_tvalid && s_tready && (s_tuser[0] == REQ_LOAD);
  assign cidx      = s_tdata[4:0];

  assign surf.invisible = s_tdata[37];
  assign surf.pos_x     = s_tdata[69:38];
  assign surf.pos_y     = s_tdata[101:70];
  assign surf.pos_z     = s_tdata[133:102];
  assign surf.radius    = s_tdata[164:134];
  assign surf.nrm_x     = s_tdata[196:165];
  assign surf.nrm_y     = s_tdata[228:197];
  assign surf.nrm_z     = s_tdata[260:229];

  // coefficient store; indexes above the normal matrix are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      mc <= '0;
      nc <= '0;
    end else if (load_xfer) begin
      if (cidx < 5'(N_MODEL)) begin
        mc[cidx[3:0]] <= s_tdata[36:5];
      end else if (cidx < 5'(N_MODEL + N_NORMAL)) begin
        nc[4'(cidx - 5'(N_MODEL))] <= s_tdata[36:5];
      end
    end
  end

  // configuration registers
  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);
  assign ridx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_plane  <= NEAR_RST;
      cfg.far_plane   <= FAR_RST;
      cfg.scale_x     <= SCALE_RST;
      cfg.scale_y     <= SCALE_RST;
      cfg.offset_x    <= '0;
      cfg.offset_y    <= '0;
      cfg.view_width  <= VIEW_RST;
      cfg.view_height <= VIEW_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (widx)
        REG_NEAR:     cfg.near_plane  <= pwdata[30:0];
        REG_FAR:      cfg.far_plane   <= pwdata[30:0];
        REG_SCALE_X:  cfg.scale_x     <= pwdata[30:0];
        REG_SCALE_Y:  cfg.scale_y     <= pwdata[30:0];
        REG_OFFSET_X: cfg.offset_x    <= pwdata;
        REG_OFFSET_Y: cfg.offset_y    <= pwdata;
        REG_WIDTH:    cfg.view_width  <= pwdata[13:0];
        REG_HEIGHT:   cfg.view_height <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_NEAR:     prdata = {1'b0, cfg.near_plane};
      REG_FAR:      prdata = {1'b0, cfg.far_plane};
      REG_SCALE_X:  prdata = {1'b0, cfg.scale_x};
      REG_SCALE_Y:  prdata = {1'b0, cfg.scale_y};
      REG_OFFSET_X: prdata = cfg.offset_x;
      REG_OFFSET_Y: prdata = cfg.offset_y;
      REG_WIDTH:    prdata = {18'd0, cfg.view_width};
      REG_HEIGHT:   prdata = {18'd0, cfg.view_height};
      default:      prdata = '0;
    endcase
  end

  spc_xform u_xform (
    .clk, .rst, .adv,
    .in_vld  (in_xfer),
    .in_s    (surf),
    .mc, .nc, .cfg,
    .out_vld (x_vld),
    .out_it  (x_it),
    .busy    (busy.xform)
  );

  spc_recip u_recip (
    .clk, .rst, .adv,
    .in_vld  (x_vld),
    .in_it   (x_it),
    .out_vld (r_vld),
    .out_it  (r_it),
    .recip,
    .busy    (busy.recip)
  );

  spc_viewport u_view (
    .clk, .rst, .adv,
    .in_vld  (r_vld),
    .in_it   (r_it),
    .recip,
    .cfg,
    .out_vld (m_tvalid),
    .out_r   (res),
    .busy    (busy.view)
  );

  assign m_tuser[0] = res.accepted;
  assign m_tdata    = {2'b00, res.cam_nrm_z, res.cam_nrm_y, res.cam_nrm_x, res.pad_y,
                       res.pad_x, res.cam_z, res.cam_y, res.cam_x, res.screen_y,
                       res.screen_x};

  // a coefficient load never overlaps surfels in flight
  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    load_xfer |-> !(busy.xform || busy.recip || busy.view))
    else $error("coefficient load while pipe busy");

  // a stalled result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // rejected surfels carry all-zero fields
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("rejected result not zero");

  // accepted surfels lie in front of the camera
  a_depth_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> $signed(m_tdata[159:128]) > 32'sd0)
    else $error("accepted surfel with non-positive depth");

endmodule

// ===== dv/surfel_project_and_cull_core_test.sv =====
// Self-checking bench for surfel_project_and_cull_core: coefficient loads, register
// writes over APB and random surfels, compared against an in-bench projection model.
// Depends on spc_pkg (register names, result struct) and the core RTL.
module surfel_project_and_cull_core_test;
  import spc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 20000;

  // Projection model plus queue of expected results
  class proj_scoreboard;
    logic signed [31:0] mcoef [N_MODEL];
    logic signed [31:0] ncoef [N_NORMAL];
    cfg_t cfg;
    res_t pending[$];
    int n_err;
    int n_hit;
    int n_miss;

    function void clear();
      foreach (mcoef[i]) mcoef[i] = '0;
      foreach (ncoef[i]) ncoef[i] = '0;
      cfg.near_plane = NEAR_RST;
      cfg.far_plane = FAR_RST;
      cfg.scale_x = SCALE_RST;
      cfg.scale_y = SCALE_RST;
      cfg.offset_x = '0;
      cfg.offset_y = '0;
      cfg.view_width = VIEW_RST;
      cfg.view_height = VIEW_RST;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_NEAR:     cfg.near_plane = v[30:0];
        REG_FAR:      cfg.far_plane = v[30:0];
        REG_SCALE_X:  cfg.scale_x = v[30:0];
        REG_SCALE_Y:  cfg.scale_y = v[30:0];
        REG_OFFSET_X: cfg.offset_x = v;
        REG_OFFSET_Y: cfg.offset_y = v;
        REG_WIDTH:    cfg.view_width = v[13:0];
        REG_HEIGHT:   cfg.view_height = v[13:0];
        default: ;
      endcase
    endfunction

    function longint clamp_s32(longint v);
      if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return -64'sh8000_0000;
      return v;
    endfunction

    function longint clamp_u31(longint v);
      if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (v < 0) return 0;
      return v;
    endfunction

    // product floored to FRAC_BITS; operands stay within 64 bits
    function longint qmul(longint a, longint b);
      longint p;
      p = a * b;
      return p >>> FRAC_BITS;
    endfunction

    function longint mat_row(longint m0, longint m1, longint m2,
                             longint a, longint b, longint c, longint t);
      return clamp_s32(qmul(m0, a) + qmul(m1, b) + qmul(m2, c) + t);
    endfunction

    function void note_input(logic req, logic [263:0] d);
      logic [4:0] idx;
      surf_t s;
      res_t r;
      longint cx, cy, cz, rc, ux, uy, sx, sy, rp, px, py;
      longint p0, p1, p2;
      longint q;
      idx = d[4:0];
      if (req == REQ_LOAD) begin
        if (idx < N_MODEL) mcoef[idx] = d[36:5];
        else if (idx < N_MODEL + N_NORMAL) ncoef[idx - N_MODEL] = d[36:5];
        return;
      end
      s.invisible = d[37];
      s.pos_x = d[69:38];
      s.pos_y = d[101:70];
      s.pos_z = d[133:102];
      s.radius = d[164:134];
      s.nrm_x = d[196:165];
      s.nrm_y = d[228:197];
      s.nrm_z = d[260:229];
      r = '0;
      p0 = s.pos_x;
      p1 = s.pos_y;
      p2 = s.pos_z;
      cz = mat_row(mcoef[6], mcoef[7], mcoef[8], p0, p1, p2, mcoef[11]);
      if (!s.invisible && cz > longint'(cfg.near_plane) && cz < longint'(cfg.far_plane)
          && cz > 0) begin
        cx = mat_row(mcoef[0], mcoef[1], mcoef[2], p0, p1, p2, mcoef[9]);
        cy = mat_row(mcoef[3], mcoef[4], mcoef[5], p0, p1, p2, mcoef[10]);
        q = (64'sd1 <<< (2 * FRAC_BITS)) / cz;
        rc = (q > 64'sh7FFF_FFFF) ? 64'sh7FFF_FFFF : q;
        ux = clamp_s32(qmul(cx, rc));
        uy = clamp_s32(qmul(cy, rc));
        sx = clamp_s32(qmul(clamp_s32(ux + longint'(cfg.offset_x)), longint'(cfg.scale_x)));
        sy = clamp_s32(qmul(clamp_s32(uy + longint'(cfg.offset_y)), longint'(cfg.scale_y)));
        rp = clamp_u31(qmul(longint'(s.radius), rc));
        px = clamp_u31(qmul(rp, longint'(cfg.scale_x)));
        py = clamp_u31(qmul(rp, longint'(cfg.scale_y)));
        if (sx >= -px && sx < (longint'(cfg.view_width) <<< FRAC_BITS) + px &&
            sy >= -py && sy < (longint'(cfg.view_height) <<< FRAC_BITS) + py) begin
          r.accepted = 1'b1;
          r.screen_x = 32'(sx);
          r.screen_y = 32'(sy);
          r.cam_x = 32'(cx);
          r.cam_y = 32'(cy);
          r.cam_z = 32'(cz);
          r.pad_x = 31'(px);
          r.pad_y = 31'(py);
          p0 = s.nrm_x;
          p1 = s.nrm_y;
          p2 = s.nrm_z;
          r.cam_nrm_x = 32'(mat_row(ncoef[0], ncoef[1], ncoef[2], p0, p1, p2, 0));
          r.cam_nrm_y = 32'(mat_row(ncoef[3], ncoef[4], ncoef[5], p0, p1, p2, 0));
          r.cam_nrm_z = 32'(mat_row(ncoef[6], ncoef[7], ncoef[8], p0, p1, p2, 0));
        end
      end
      if (r.accepted) n_hit++;
      else n_miss++;
      pending.push_back(r);
    endfunction

    function void cmp(string nm, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $display("%0t mismatch %s expected %h actual %h", $realtime, nm, e, a);
        n_err++;
      end
    endfunction

    function void check_result(logic [0:0] u, logic [319:0] d);
      res_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result accepted=%0d data=%h", $realtime, u, d);
        n_err++;
        return;
      end
      e = pending.pop_front();
      cmp("accepted", 32'(e.accepted), 32'(u));
      cmp("screen_x", e.screen_x, d[31:0]);
      cmp("screen_y", e.screen_y, d[63:32]);
      cmp("cam_x", e.cam_x, d[95:64]);
      cmp("cam_y", e.cam_y, d[127:96]);
      cmp("cam_z", e.cam_z, d[159:128]);
      cmp("pad_x", 32'(e.pad_x), 32'(d[190:160]));
      cmp("pad_y", 32'(e.pad_y), 32'(d[221:191]));
      cmp("cam_nrm_x", e.cam_nrm_x, d[253:222]);
      cmp("cam_nrm_y", e.cam_nrm_y, d[285:254]);
      cmp("cam_nrm_z", e.cam_nrm_z, d[317:286]);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic [263:0] s_tdata;
  logic [0:0] s_tuser;
  logic s_tvalid;
  logic s_tready;
  logic [319:0] m_tdata;
  logic [0:0] m_tuser;
  logic m_tvalid;
  logic m_tready;
  logic psel;
  logic penable;
  logic pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  proj_scoreboard sb;
  int idle_cycles;
  int stall_mode;
  int n_sent;
  bit timed_out;

  surfel_project_and_cull_core u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: check at each rising edge, stall pattern changes by phase
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(negedge clk) begin
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog on cycles without any transfer
  initial begin
    timed_out = 1'b0;
    wait (idle_cycles >= WATCHDOG_LIMIT);
    timed_out = 1'b1;
    $display("%0t watchdog: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // One transfer into the core; valid stays up across a burst, else drops after the transfer
  task automatic send_item(logic req, logic [263:0] d, bit keep);
    s_tuser <= req;
    s_tdata <= d;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(req, d);
    n_sent++;
    @(negedge clk);
    if (!keep) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic burst_gap();
    int g;
    g = $urandom_range(0, 4);
    repeat (g) @(negedge clk);
  endtask

  task automatic load_coef(logic [4:0] idx, logic [31:0] v);
    send_item(REQ_LOAD, {227'b0, v, idx}, 1'b0);
  endtask

  task automatic send_surfel(bit inv, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [30:0] rad, logic [31:0] nx, logic [31:0] ny,
                             logic [31:0] nz, bit keep);
    send_item(~REQ_LOAD, {3'b0, nz, ny, nx, rad, pz, py, px, inv, 37'b0}, keep);
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Identity-like model and normal matrices with small perturbations and translations, or all random if wild
  task automatic load_matrices(bit wild);
    for (int i = 0; i < N_MODEL + N_NORMAL; i++) begin
      logic [31:0] v;
      if (wild) v = $urandom();
      else if (i == 0 || i == 4 || i == 8 || i == 12 || i == 16 || i == 20)
        v = 32'h0001_0000 + $urandom_range(0, 4096) - 2048;
      else if (i == 11) v = $urandom_range(1, 64) << 16;
      else if (i == 9 || i == 10) v = $urandom_range(0, 512) << 16;
      else v = $urandom_range(0, 8192) - 4096;
      load_coef(i[4:0], v);
    end
  endtask

  task automatic random_surfels(int n, bit wild);
    for (int k = 0; k < n; k++) begin
      logic [31:0] px, py, pz;
      bit keep;
      keep = ($urandom_range(0, 3) != 0);
      if (wild || $urandom_range(0, 5) == 0) begin
        px = $urandom();
        py = $urandom();
        pz = $urandom();
      end else begin
        px = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        py = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        pz = $urandom_range(0, 32'h0080_0000);
      end
      if ($urandom_range(0, 30) == 0) load_coef(5'(21 + $urandom_range(0, 10)), $urandom());
      send_surfel($urandom_range(0, 7) == 0, px, py, pz,
                  31'($urandom() >> 1 >> $urandom_range(0, 20)),
                  $urandom(), $urandom(), $urandom(), keep);
      if (!keep) burst_gap();
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    sb = new();
    sb.clear();
    sb.n_err = 0;
    n_sent = 0;
    idle_cycles = 0;
    stall_mode = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero store, hidden surfel, identity matrices, depth and extremes
    send_surfel(1'b0, 32'h0001_0000, 0, 32'h0002_0000, 31'h1_0000, 1, 2, 3, 1'b0);
    load_coef(5'd0, 32'h0001_0000);
    load_coef(5'd4, 32'h0001_0000);
    load_coef(5'd8, 32'h0001_0000);
    load_coef(5'd12, 32'h0001_0000);
    load_coef(5'd16, 32'h0001_0000);
    load_coef(5'd20, 32'h0001_0000);
    load_coef(5'd31, 32'hFFFF_FFFF);
    send_surfel(1'b1, 32'h0010_0000, 32'h0010_0000, 32'h0004_0000, 31'h1_0000, 1, 2, 3, 1'b0);
    send_surfel(1'b0, 32'h0010_0000, 32'h0010_0000, 32'h0004_0000, 31'h1_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_surfel(1'b0, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 1'b0);
    send_surfel(1'b0, 0, 0, 32'h0001_0001, 31'h7FFF_FFFF, 0, 0, 0, 1'b0);
    send_surfel(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                0, 0, 0, 1'b0);
    send_surfel(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 1'b0);
    wait_drained();
    write_reg(REG_NEAR, 0);
    send_surfel(1'b0, 32'h0000_0100, 0, 32'h0000_0001, 31'h10, 1, 1, 1, 1'b0);
    send_surfel(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0002, 31'h7FFF_FFFF,
                5, 6, 7, 1'b0);
    wait_drained();

    // Random phases over several register settings, extremes included
    for (int ph = 0; ph < 9; ph++) begin
      stall_mode = ph % 3;
      wait_drained();
      case (ph)
        0: begin
          write_reg(REG_NEAR, 32'h0000_8000);
          write_reg(REG_FAR, 32'h0100_0000);
          write_reg(REG_SCALE_X, 32'h0100_0000);
          write_reg(REG_SCALE_Y, 32'h0080_0000);
          write_reg(REG_OFFSET_X, 32'h0001_0000);
          write_reg(REG_OFFSET_Y, 32'h0001_0000);
          write_reg(REG_WIDTH, 1920);
          write_reg(REG_HEIGHT, 1080);
        end
        1: begin
          write_reg(REG_WIDTH, 0);
          write_reg(REG_HEIGHT, 32'h3FFF);
          write_reg(REG_SCALE_X, 0);
        end
        2: begin
          write_reg(REG_NEAR, 32'h7FFF_FFFF);
          write_reg(REG_FAR, 0);
        end
        3: begin
          write_reg(REG_NEAR, 0);
          write_reg(REG_FAR, 32'h7FFF_FFFF);
          write_reg(REG_SCALE_X, 32'h7FFF_FFFF);
          write_reg(REG_SCALE_Y, 32'h7FFF_FFFF);
          write_reg(REG_OFFSET_X, 32'h8000_0000);
          write_reg(REG_OFFSET_Y, 32'h7FFF_FFFF);
          write_reg(REG_WIDTH, 8192);
          write_reg(REG_HEIGHT, 1);
        end
        default: begin
          write_reg(REG_NEAR, $urandom_range(0, 32'h0002_0000));
          write_reg(REG_FAR, $urandom() >> 1);
          write_reg(REG_SCALE_X, $urandom_range(0, 32'h0400_0000));
          write_reg(REG_SCALE_Y, $urandom_range(0, 32'h0400_0000));
          write_reg(REG_OFFSET_X, $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
          write_reg(REG_OFFSET_Y, $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
          write_reg(REG_WIDTH, $urandom_range(1, 8192));
          write_reg(REG_HEIGHT, $urandom_range(1, 8192));
        end
      endcase
      load_matrices(ph == 5);
      random_surfels(30, ph == 6);
    end

    wait_drained();
    $display("Sent %0d transfers: %0d surfels kept, %0d culled, 9 register settings.",
             n_sent, sb.n_hit, sb.n_miss);
    if (sb.n_err == 0 && sb.pending.size() == 0 && !timed_out) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.n_err, sb.pending.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
